### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks sampled on clk, held off while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, with the consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/pil_pkg.sv
`default_nettype none

package pil_pkg;

  localparam int TYPE_W = 3;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 7;
  localparam int POS2_W = 6;
  localparam int CNT_W  = 7;
  localparam int STAT_W = 2;
  localparam int MAJ_W  = 2;

  localparam logic [TYPE_W-1:0] REQ_INSERT   = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_APPEND   = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_REMOVE   = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_READ     = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_REPLACE  = 3'd4;
  localparam logic [TYPE_W-1:0] REQ_SWAP     = 3'd5;
  localparam logic [TYPE_W-1:0] REQ_MAJORITY = 3'd6;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  localparam logic [MAJ_W-1:0] MAJ_NONNEG = 2'd0;
  localparam logic [MAJ_W-1:0] MAJ_NEG    = 2'd1;
  localparam logic [MAJ_W-1:0] MAJ_EQUAL  = 2'd2;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_UP_INIT,
    OP_UP_STEP,
    OP_UP_PUT,
    OP_DN_INIT,
    OP_DN_STEP,
    OP_DN_END,
    OP_RD_P1,
    OP_HOLD,
    OP_REPL,
    OP_SWAP_B,
    OP_SWAP_C,
    OP_SWAP_D,
    OP_CNT_INIT,
    OP_CNT_STEP,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t status;
    logic    rv_take;
    logic    maj_take;
  } dp_cmd_t;

  typedef struct packed {
    logic [TYPE_W-1:0] req;
    logic              ins_range;
    logic              full;
    logic              empty;
    logic              pos_range;
    logic              pos2_range;
    logic              up_done;
    logic              dn_done;
    logic              cnt_done;
  } dp_sts_t;

endpackage

`default_nettype wire

### rtl/pil_ctrl.sv
`default_nettype none

module pil_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output pil_pkg::dp_cmd_t      cmd,
  input  wire pil_pkg::dp_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_UP,
    S_DN,
    S_RD,
    S_SWC,
    S_SWD,
    S_CNT,
    S_FIN
  } state_t;

  state_t           state_r, state_nxt;
  pil_pkg::status_t st_r, st_nxt;
  logic             rv_take_r, rv_take_nxt;
  logic             maj_take_r, maj_take_nxt;
  logic             out_valid_r, out_valid_nxt;
  pil_pkg::dp_op_t  op;

  always_comb begin
    state_nxt     = state_r;
    st_nxt        = st_r;
    rv_take_nxt   = rv_take_r;
    maj_take_nxt  = maj_take_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    op            = pil_pkg::OP_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = pil_pkg::OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        st_nxt       = pil_pkg::ST_OK;
        rv_take_nxt  = 1'b0;
        maj_take_nxt = 1'b0;
        state_nxt    = S_FIN;
        unique case (sts.req) inside
          pil_pkg::REQ_INSERT, pil_pkg::REQ_APPEND: begin
            if (sts.ins_range) begin
              st_nxt = pil_pkg::ST_RANGE;
            end else if (sts.full) begin
              st_nxt = pil_pkg::ST_FULL;
            end else begin
              op        = pil_pkg::OP_UP_INIT;
              state_nxt = S_UP;
            end
          end
          pil_pkg::REQ_REMOVE: begin
            if (sts.empty) begin
              st_nxt = pil_pkg::ST_EMPTY;
            end else if (sts.pos_range) begin
              st_nxt = pil_pkg::ST_RANGE;
            end else begin
              op        = pil_pkg::OP_DN_INIT;
              state_nxt = S_DN;
            end
          end
          pil_pkg::REQ_READ, pil_pkg::REQ_REPLACE: begin
            if (sts.empty) begin
              st_nxt = pil_pkg::ST_EMPTY;
            end else if (sts.pos_range) begin
              st_nxt = pil_pkg::ST_RANGE;
            end else begin
              op          = pil_pkg::OP_RD_P1;
              rv_take_nxt = 1'b1;
              state_nxt   = S_RD;
            end
          end
          pil_pkg::REQ_SWAP: begin
            if (sts.empty) begin
              st_nxt = pil_pkg::ST_EMPTY;
            end else if (sts.pos_range || sts.pos2_range) begin
              st_nxt = pil_pkg::ST_RANGE;
            end else begin
              op        = pil_pkg::OP_RD_P1;
              state_nxt = S_RD;
            end
          end
          pil_pkg::REQ_MAJORITY: begin
            op           = pil_pkg::OP_CNT_INIT;
            maj_take_nxt = 1'b1;
            state_nxt    = S_CNT;
          end
          default: ;
        endcase
      end
      S_UP: begin
        if (sts.up_done) begin
          op        = pil_pkg::OP_UP_PUT;
          state_nxt = S_FIN;
        end else begin
          op = pil_pkg::OP_UP_STEP;
        end
      end
      S_DN: begin
        if (sts.dn_done) begin
          op        = pil_pkg::OP_DN_END;
          state_nxt = S_FIN;
        end else begin
          op = pil_pkg::OP_DN_STEP;
        end
      end
      S_RD: begin
        unique case (sts.req) inside
          pil_pkg::REQ_SWAP: begin
            op        = pil_pkg::OP_SWAP_B;
            state_nxt = S_SWC;
          end
          pil_pkg::REQ_REPLACE: begin
            op        = pil_pkg::OP_REPL;
            state_nxt = S_FIN;
          end
          default: begin
            op        = pil_pkg::OP_HOLD;
            state_nxt = S_FIN;
          end
        endcase
      end
      S_SWC: begin
        op        = pil_pkg::OP_SWAP_C;
        state_nxt = S_SWD;
      end
      S_SWD: begin
        op        = pil_pkg::OP_SWAP_D;
        state_nxt = S_FIN;
      end
      S_CNT: begin
        if (sts.cnt_done) begin
          state_nxt = S_FIN;
        end else begin
          op = pil_pkg::OP_CNT_STEP;
        end
      end
      S_FIN: begin
        // hold the result here until the output register is free
        if (!out_valid_r || out_ready) begin
          op            = pil_pkg::OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      st_r        <= pil_pkg::ST_OK;
      rv_take_r   <= 1'b0;
      maj_take_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      st_r        <= st_nxt;
      rv_take_r   <= rv_take_nxt;
      maj_take_r  <= maj_take_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign cmd.op       = op;
  assign cmd.status   = st_r;
  assign cmd.rv_take  = rv_take_r;
  assign cmd.maj_take = maj_take_r;

endmodule

`default_nettype wire

### rtl/pil_dpath.sv
`default_nettype none

module pil_dpath #(
  parameter int CAPACITY = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire pil_pkg::dp_cmd_t                    cmd,
  output pil_pkg::dp_sts_t                         sts,
  input  wire logic [pil_pkg::TYPE_W-1:0]          in_req_type,
  input  wire logic signed [pil_pkg::VAL_W-1:0]    in_value,
  input  wire logic [pil_pkg::POS_W-1:0]           in_position,
  input  wire logic [pil_pkg::POS2_W-1:0]          in_second_position,
  output logic [pil_pkg::STAT_W-1:0]               out_status,
  output logic signed [pil_pkg::VAL_W-1:0]         out_read_value,
  output logic [pil_pkg::CNT_W-1:0]                out_entry_count,
  output logic                                     out_is_empty,
  output logic [pil_pkg::MAJ_W-1:0]                out_majority
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > pil_pkg::POS_W) ? CW : pil_pkg::POS_W;

  logic [pil_pkg::VAL_W-1:0]  mem [CAPACITY];
  logic [pil_pkg::VAL_W-1:0]  rdata_r;
  logic [pil_pkg::VAL_W-1:0]  hold_r;

  logic [pil_pkg::TYPE_W-1:0] req_type_r;
  logic [pil_pkg::VAL_W-1:0]  value_r;
  logic [pil_pkg::POS_W-1:0]  pos_r;
  logic [pil_pkg::POS2_W-1:0] pos2_r;

  logic [CW-1:0]              total_r;
  logic [CW-1:0]              idx_r;
  logic [CW-1:0]              wa_r;
  logic                       pend_r;
  logic [CW-1:0]              neg_r;

  logic [pil_pkg::STAT_W-1:0] status_r;
  logic [pil_pkg::VAL_W-1:0]  read_value_r;
  logic [pil_pkg::CNT_W-1:0]  count_r;
  logic                       empty_r;
  logic [pil_pkg::MAJ_W-1:0]  maj_r;

  logic [XW-1:0] total_x, idx_x, idx_p1_x, pos_x, pos2_x, ins_x;
  logic          up_more, dn_more, cnt_more;
  logic [CW:0]   two_neg, total_w;
  logic [pil_pkg::MAJ_W-1:0] maj_val;

  logic                      we;
  logic [AW-1:0]             waddr, raddr;
  logic [pil_pkg::VAL_W-1:0] wdata;

  assign total_x  = XW'(total_r);
  assign idx_x    = XW'(idx_r);
  assign idx_p1_x = idx_x + XW'(1);
  assign pos_x    = XW'(pos_r);
  assign pos2_x   = XW'(pos2_r);
  assign ins_x    = (req_type_r == pil_pkg::REQ_APPEND) ? total_x : pos_x;

  assign up_more  = (idx_x > ins_x);
  assign dn_more  = (idx_p1_x < total_x);
  assign cnt_more = (idx_x < total_x);

  assign sts.req        = req_type_r;
  assign sts.ins_range  = (ins_x > total_x);
  assign sts.full       = (total_x >= XW'(CAPACITY));
  assign sts.empty      = (total_r == '0);
  assign sts.pos_range  = (pos_x >= total_x);
  assign sts.pos2_range = (pos2_x >= total_x);
  assign sts.up_done    = !pend_r && !up_more;
  assign sts.dn_done    = !pend_r && !dn_more;
  assign sts.cnt_done   = !pend_r && !cnt_more;

  // 2*neg against total decides the sign majority
  assign two_neg = {neg_r, 1'b0};
  assign total_w = {1'b0, total_r};
  assign maj_val = (two_neg < total_w) ? pil_pkg::MAJ_NONNEG :
                   (two_neg > total_w) ? pil_pkg::MAJ_NEG : pil_pkg::MAJ_EQUAL;

  // memory port selection; shifts read one entry ahead of the pending write
  always_comb begin
    we    = 1'b0;
    waddr = AW'(wa_r);
    wdata = rdata_r;
    raddr = AW'(idx_r);
    case (cmd.op)
      pil_pkg::OP_UP_STEP: begin
        we    = pend_r;
        raddr = AW'(idx_r - CW'(1));
      end
      pil_pkg::OP_UP_PUT: begin
        we    = 1'b1;
        waddr = AW'(ins_x);
        wdata = value_r;
      end
      pil_pkg::OP_DN_STEP: begin
        we    = pend_r;
        raddr = AW'(idx_p1_x);
      end
      pil_pkg::OP_RD_P1: raddr = AW'(pos_x);
      pil_pkg::OP_REPL: begin
        we    = 1'b1;
        waddr = AW'(pos_x);
        wdata = value_r;
      end
      pil_pkg::OP_SWAP_B: raddr = AW'(pos2_x);
      pil_pkg::OP_SWAP_C: begin
        we    = 1'b1;
        waddr = AW'(pos_x);
        wdata = rdata_r;
      end
      pil_pkg::OP_SWAP_D: begin
        we    = 1'b1;
        waddr = AW'(pos2_x);
        wdata = hold_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      idx_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      case (cmd.op)
        pil_pkg::OP_UP_INIT: begin
          idx_r  <= total_r;
          pend_r <= 1'b0;
        end
        pil_pkg::OP_UP_STEP: begin
          pend_r <= up_more;
          if (up_more) begin
            idx_r <= idx_r - CW'(1);
          end
        end
        pil_pkg::OP_UP_PUT: total_r <= total_r + CW'(1);
        pil_pkg::OP_DN_INIT: begin
          idx_r  <= CW'(pos_x);
          pend_r <= 1'b0;
        end
        pil_pkg::OP_DN_STEP: begin
          pend_r <= dn_more;
          if (dn_more) begin
            idx_r <= idx_r + CW'(1);
          end
        end
        pil_pkg::OP_DN_END: total_r <= total_r - CW'(1);
        pil_pkg::OP_CNT_INIT: begin
          idx_r  <= '0;
          pend_r <= 1'b0;
        end
        pil_pkg::OP_CNT_STEP: begin
          pend_r <= cnt_more;
          if (cnt_more) begin
            idx_r <= idx_r + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      pil_pkg::OP_LOAD: begin
        req_type_r <= in_req_type;
        value_r    <= in_value;
        pos_r      <= in_position;
        pos2_r     <= in_second_position;
      end
      pil_pkg::OP_UP_STEP: wa_r <= idx_r;
      pil_pkg::OP_DN_STEP: wa_r <= idx_r;
      pil_pkg::OP_HOLD, pil_pkg::OP_REPL, pil_pkg::OP_SWAP_B: hold_r <= rdata_r;
      pil_pkg::OP_CNT_INIT: neg_r <= '0;
      pil_pkg::OP_CNT_STEP: begin
        if (pend_r) begin
          neg_r <= neg_r + CW'(rdata_r[pil_pkg::VAL_W-1]);
        end
      end
      pil_pkg::OP_OUT: begin
        status_r     <= cmd.status;
        read_value_r <= cmd.rv_take ? hold_r : '0;
        count_r      <= total_x[pil_pkg::CNT_W-1:0];
        empty_r      <= (total_r == '0);
        maj_r        <= cmd.maj_take ? maj_val : pil_pkg::MAJ_NONNEG;
      end
      default: ;
    endcase
  end

  assign out_status      = status_r;
  assign out_read_value  = read_value_r;
  assign out_entry_count = count_r;
  assign out_is_empty    = empty_r;
  assign out_majority    = maj_r;

endmodule

`default_nettype wire

### rtl/positional_integer_list_top.sv
// Positional integer list: an ordered list of up to CAPACITY signed 32-bit
// entries, head at position 0, held in a single-port-write, registered-read
// memory and driven by a controller state machine.
// Input channel (in_valid/in_ready) carries one request per beat: req_type,
// value, position, second_position. Output channel (out_valid/out_ready)
// returns one result per request: status, read_value, entry_count,
// is_empty, majority.
// One request is in flight at a time; in_ready is high only when the
// controller is idle. A rejected request or an unused code goes straight
// to the result; read and replace fetch the entry at position, and replace
// then writes the new value there; swap exchanges the entries at both
// positions; insert shifts the entries from position up by one (append
// shifts none), remove shifts them down by one; sign majority reads one
// entry per cycle. The controller returns to idle, raising in_ready, as
// the result is loaded into the output register.
// The result sits in an output register: a stalled receiver does not stop
// the next request from being accepted and worked, only its result waits.
// Synchronous reset empties the list; memory contents stay undefined and
// are never used before being written.
`default_nettype none

`include "assert_macros.svh"

module positional_integer_list_top #(
  parameter int CAPACITY = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [pil_pkg::TYPE_W-1:0]       in_req_type,
  input  wire logic signed [pil_pkg::VAL_W-1:0] in_value,
  input  wire logic [pil_pkg::POS_W-1:0]        in_position,
  input  wire logic [pil_pkg::POS2_W-1:0]       in_second_position,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [pil_pkg::STAT_W-1:0]            out_status,
  output logic signed [pil_pkg::VAL_W-1:0]      out_read_value,
  output logic [pil_pkg::CNT_W-1:0]             out_entry_count,
  output logic                                  out_is_empty,
  output logic [pil_pkg::MAJ_W-1:0]             out_majority
);

  pil_pkg::dp_cmd_t cmd;
  pil_pkg::dp_sts_t sts;

  pil_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  pil_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_req_type        (in_req_type),
    .in_value           (in_value),
    .in_position        (in_position),
    .in_second_position (in_second_position),
    .out_status         (out_status),
    .out_read_value     (out_read_value),
    .out_entry_count    (out_entry_count),
    .out_is_empty       (out_is_empty),
    .out_majority       (out_majority)
  );

  `ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second beat taken while busy")
  `ASSERT_CLK(a_put_not_full, (cmd.op == pil_pkg::OP_UP_PUT) |-> !sts.full, "insert into full list")
  `ASSERT_CLK(a_del_not_empty, (cmd.op == pil_pkg::OP_DN_END) |-> !sts.empty, "remove from empty list")
  `ASSERT_CLK(a_no_overwrite, (cmd.op == pil_pkg::OP_OUT) |-> (!out_valid || out_ready), "pending result overwritten")

endmodule

`default_nettype wire
